[sv/gda_pkg.sv]
// ----------------------------------------------------------------------------
// gda_pkg
// Shared widths, calendar tables and pipeline stage types for the
// Gregorian date arithmetic unit.
// ----------------------------------------------------------------------------
package gda_pkg;

	localparam int unsigned MAX_YEAR_DEF = 9999;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned DOY_W   = 9;
	localparam int unsigned DN_W    = 22;
	localparam int unsigned SN_W    = 23;
	localparam int unsigned WD_W    = 3;

	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 104;

	// floor(x / 25) == (x * RECIP25) >> RECIP_SH for x < 4096
	localparam logic [12:0] RECIP25  = 13'd5243;
	localparam int unsigned RECIP_SH = 17;

	localparam logic [3:0] MON_JAN = 4'd1;
	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_MAR = 4'd3;
	localparam logic [3:0] MON_APR = 4'd4;
	localparam logic [3:0] MON_MAY = 4'd5;
	localparam logic [3:0] MON_JUN = 4'd6;
	localparam logic [3:0] MON_JUL = 4'd7;
	localparam logic [3:0] MON_AUG = 4'd8;
	localparam logic [3:0] MON_SEP = 4'd9;
	localparam logic [3:0] MON_OCT = 4'd10;
	localparam logic [3:0] MON_NOV = 4'd11;
	localparam logic [3:0] MON_DEC = 4'd12;

	localparam logic [4:0] DEC_LEN = 5'd31;

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			MON_JAN, MON_MAR, MON_MAY, MON_JUL,
			MON_AUG, MON_OCT, MON_DEC: n = 5'd31;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: n = 5'd30;
			MON_FEB: n = leap ? 5'd29 : 5'd28;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

	// days in the months before m
	function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
		logic [8:0] n;
		case (m)
			MON_JAN: n = 9'd0;
			MON_FEB: n = 9'd31;
			MON_MAR: n = 9'd59;
			MON_APR: n = 9'd90;
			MON_MAY: n = 9'd120;
			MON_JUN: n = 9'd151;
			MON_JUL: n = 9'd181;
			MON_AUG: n = 9'd212;
			MON_SEP: n = 9'd243;
			MON_OCT: n = 9'd273;
			MON_NOV: n = 9'd304;
			MON_DEC: n = 9'd334;
			default: n = 9'd0;
		endcase
		if (leap && m > MON_FEB) begin
			n = n + 9'd1;
		end
		return n;
	endfunction

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} date_t;

	typedef struct packed {
		date_t       dt;
		logic        rng_ok;
		logic [22:0] base1;
		logic [7:0]  div100;
		logic [7:0]  y4d25;
		logic [5:0]  y16d25;
	} lane_s1_t;

	typedef struct packed {
		logic        valid;
		logic        leap;
		logic [8:0]  doy;
		logic [22:0] base2;
	} lane_s2_t;

	typedef struct packed {
		logic [4:0]  nday;
		logic [3:0]  nmonth;
		logic [13:0] nyear;
		logic [4:0]  pday;
		logic [3:0]  pmonth;
		logic [13:0] pyear;
	} nav_t;

	typedef struct packed {
		logic        valid;
		logic        leap;
		logic [8:0]  doy;
		nav_t        nav;
		logic [22:0] sn0;
		logic [22:0] sn1;
	} mid_s3_t;

	typedef struct packed {
		logic        valid;
		logic        leap;
		logic [8:0]  doy;
		logic [21:0] dn;
		logic [2:0]  wd;
		nav_t        nav;
		logic [22:0] diff;
	} result_t;

endpackage

[sv/gregorian_date_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_unit
// Proleptic Gregorian day number, weekday, neighbor dates and day
// difference of two dates, in a four-stage pipeline.
// ----------------------------------------------------------------------------
// channel   group        fields
// input     s_tdata      first date, second date
// output    m_tdata      leap, day of year, day number, weekday, next/prev, diff
// output    m_tuser      first date valid
//
// One transaction per cycle sustained while the output is not stalled.
// Stages: year split and reciprocal multiplies, leap/validity
// and year base, day number, weekday fold and difference.
// Reset clears only the stage valid bits. A stalled output freezes the stages
// behind it; empty stages still fill, so no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_unit
	import gda_pkg::*;
#(
	parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// day, month, year, other_day, other_month, other_year, 2 pad bits
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// is_leap, day_of_year, day_number, weekday, next_day, next_month,
	// next_year, prev_day, prev_month, prev_year, day_difference
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// is_valid
	output logic                   m_tuser
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	lane_s1_t lane_s1 [2];
	lane_s2_t lane_s2 [2];
	nav_t     nav_s2;
	mid_s3_t  mid_s3;
	result_t  res_s4;

	date_t    din [2];
	lane_s1_t lane_d1 [2];
	lane_s2_t lane_d2 [2];
	nav_t     nav_d2;
	mid_s3_t  mid_d3;
	result_t  res_d4;

	assign en4 = !v_s4 || m_tready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	assign din[0] = '{day: s_tdata[4:0], month: s_tdata[8:5], year: s_tdata[22:9]};
	assign din[1] = '{day: s_tdata[27:23], month: s_tdata[31:28], year: s_tdata[45:32]};

	// stage 1: year split, reciprocal multiplies, range checks
	always_comb begin
		logic [13:0] p;
		logic [11:0] q4;
		logic [24:0] m100;
		logic [24:0] my4;
		logic [22:0] my16;
		for (int i = 0; i < 2; i++) begin
			p    = din[i].year - 14'd1;
			q4   = p[13:2];
			m100 = 25'(q4) * 25'(RECIP25);
			my4  = 25'(din[i].year[13:2]) * 25'(RECIP25);
			my16 = 23'(din[i].year[13:4]) * 23'(RECIP25);
			lane_d1[i].dt     = din[i];
			lane_d1[i].rng_ok = (din[i].year != '0) && (32'(din[i].year) <= MAX_YEAR) &&
				(din[i].month >= MON_JAN) && (din[i].month <= MON_DEC) &&
				(din[i].day != '0);
			lane_d1[i].base1  = 23'(p) * 23'd365 + 23'(q4);
			lane_d1[i].div100 = m100[RECIP_SH +: 8];
			lane_d1[i].y4d25  = my4[RECIP_SH +: 8];
			lane_d1[i].y16d25 = my16[RECIP_SH +: 6];
		end
	end

	// stage 2: leap, validity, ordinal, year base, neighbor dates
	always_comb begin
		logic        y100, y400, leap, ok;
		logic [4:0]  mlen;
		date_t       dt;
		nav_t        nv;
		for (int i = 0; i < 2; i++) begin
			dt   = lane_s1[i].dt;
			y100 = (dt.year[1:0] == 2'd0) &&
				(12'(lane_s1[i].y4d25) * 12'd25 == dt.year[13:2]);
			y400 = (dt.year[3:0] == 4'd0) &&
				(10'(lane_s1[i].y16d25) * 10'd25 == dt.year[13:4]);
			leap = (dt.year[1:0] == 2'd0) && (!y100 || y400);
			mlen = month_days(dt.month, leap);
			ok   = lane_s1[i].rng_ok && (dt.day <= mlen);
			lane_d2[i].valid = ok;
			lane_d2[i].leap  = ok && leap;
			lane_d2[i].doy   = ok ? cum_days(dt.month, leap) + 9'(dt.day) : '0;
			lane_d2[i].base2 = lane_s1[i].base1 - 23'(lane_s1[i].div100) +
				23'(lane_s1[i].div100[7:2]);
		end

		dt   = lane_s1[0].dt;
		y100 = (dt.year[1:0] == 2'd0) && (12'(lane_s1[0].y4d25) * 12'd25 == dt.year[13:2]);
		y400 = (dt.year[3:0] == 4'd0) && (10'(lane_s1[0].y16d25) * 10'd25 == dt.year[13:4]);
		leap = (dt.year[1:0] == 2'd0) && (!y100 || y400);
		mlen = month_days(dt.month, leap);
		nv.nday   = dt.day + 5'd1;
		nv.nmonth = dt.month;
		nv.nyear  = dt.year;
		if (dt.day == mlen) begin
			nv.nday = 5'd1;
			if (dt.month == MON_DEC) begin
				nv.nmonth = MON_JAN;
				nv.nyear  = dt.year + 14'd1;
			end else begin
				nv.nmonth = dt.month + 4'd1;
			end
		end
		nv.pday   = dt.day - 5'd1;
		nv.pmonth = dt.month;
		nv.pyear  = dt.year;
		if (dt.day == 5'd1) begin
			if (dt.month == MON_JAN) begin
				nv.pmonth = MON_DEC;
				nv.pyear  = dt.year - 14'd1;
				nv.pday   = DEC_LEN;
			end else begin
				nv.pmonth = dt.month - 4'd1;
				nv.pday   = month_days(dt.month - 4'd1, leap);
			end
		end
		nav_d2 = lane_d2[0].valid ? nv : '0;
	end

	// stage 3: day numbers
	always_comb begin
		mid_d3.valid = lane_s2[0].valid;
		mid_d3.leap  = lane_s2[0].leap;
		mid_d3.doy   = lane_s2[0].doy;
		mid_d3.nav   = nav_s2;
		mid_d3.sn0   = lane_s2[0].valid ? lane_s2[0].base2 + 23'(lane_s2[0].doy) : '0;
		mid_d3.sn1   = lane_s2[1].valid ? lane_s2[1].base2 + 23'(lane_s2[1].doy) : '0;
	end

	// stage 4: weekday by octal digit sum (8 == 1 mod 7), difference
	always_comb begin
		logic [23:0] snx;
		logic [5:0]  dsum;
		logic [3:0]  s2;
		logic [2:0]  r;
		snx  = {1'b0, mid_s3.sn0};
		dsum = '0;
		for (int k = 0; k < 8; k++) begin
			dsum = dsum + 6'(snx[3*k +: 3]);
		end
		s2 = 4'(dsum[5:3]) + 4'(dsum[2:0]);
		r  = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
		res_d4.valid = mid_s3.valid;
		res_d4.leap  = mid_s3.leap;
		res_d4.doy   = mid_s3.doy;
		res_d4.dn    = mid_s3.sn0[21:0];
		res_d4.wd    = !mid_s3.valid ? 3'd0 : ((r == 3'd0) ? 3'd7 : r);
		res_d4.nav   = mid_s3.nav;
		res_d4.diff  = mid_s3.sn0 - mid_s3.sn1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			lane_s1 <= lane_d1;
		end
		if (en2 && v_s1) begin
			lane_s2 <= lane_d2;
			nav_s2  <= nav_d2;
		end
		if (en3 && v_s2) begin
			mid_s3 <= mid_d3;
		end
		if (en4 && v_s3) begin
			res_s4 <= res_d4;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tuser  = res_s4.valid;
	assign m_tdata  = {res_s4.diff,
		res_s4.nav.pyear, res_s4.nav.pmonth, res_s4.nav.pday,
		res_s4.nav.nyear, res_s4.nav.nmonth, res_s4.nav.nday,
		res_s4.wd, res_s4.dn, res_s4.doy, res_s4.leap};

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[80:0] == '0)
		else $error("invalid date with nonzero derived fields");

	a_weekday_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[34:32] != 3'd0)
		else $error("valid date with zero weekday");

	a_doy_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[9:1] != 9'd0 && m_tdata[9:1] <= 9'd366)
		else $error("day of year out of range");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted transaction not in stage 1");

	a_stage3_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !en4 |=> v_s3)
		else $error("stalled stage 3 transaction dropped");

endmodule

[dv/tb_gregorian_date_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_date_arithmetic_unit
// Self-checking bench for the Gregorian date arithmetic unit. A queue of
// date pairs (hand-picked calendar corners first, then random valid,
// month-end, corrupted and raw-bit dates) feeds a stream driver. Each
// accepted transaction is run through a behavioral calendar model and the
// answer is queued. The monitor checks every output transaction field by
// field against the oldest queued answer. Both sides idle at random, and once
// the receiver holds off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_gregorian_date_arithmetic_unit;
	import gda_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1950;
	localparam int unsigned HOLD_CYCLES  = 120;
	localparam int unsigned HOLD_AT      = 600;
	localparam int unsigned DRAIN_CYCLES = 12;

	typedef struct packed {
		logic        valid;
		logic        leap;
		logic [8:0]  doy;
		logic [21:0] dn;
		logic [2:0]  wd;
		logic [4:0]  nday;
		logic [3:0]  nmonth;
		logic [13:0] nyear;
		logic [4:0]  pday;
		logic [3:0]  pmonth;
		logic [13:0] pyear;
		logic [22:0] diff;
	} calendar_answer_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	logic [IN_TDATA_W-1:0] pending_dates[$];
	calendar_answer_t      expected_answers[$];

	int unsigned sent_cnt = 0;
	int unsigned got_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_wait = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	gregorian_date_arithmetic_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// ---------------- calendar model ----------------
	function automatic bit is_leap_year(int unsigned y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function automatic int unsigned month_len(int unsigned m, int unsigned y);
		if (m == MON_FEB) begin
			return is_leap_year(y) ? 29 : 28;
		end
		if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
			return 30;
		end
		return 31;
	endfunction

	function automatic bit real_date(int unsigned d, int unsigned m, int unsigned y);
		if (y < 1 || y > MAX_YEAR_DEF) begin
			return 1'b0;
		end
		if (m < MON_JAN || m > MON_DEC) begin
			return 1'b0;
		end
		return (d >= 1) && (d <= month_len(m, y));
	endfunction

	function automatic int unsigned ordinal_day(int unsigned d, int unsigned m,
			int unsigned y);
		int unsigned acc;
		acc = d;
		for (int unsigned i = 32'(MON_JAN); i < m && i <= MON_DEC; i++) begin
			acc += month_len(i, y);
		end
		return acc;
	endfunction

	function automatic int unsigned day_count(int unsigned d, int unsigned m,
			int unsigned y);
		int unsigned p;
		if (!real_date(d, m, y)) begin
			return 0;
		end
		p = y - 1;
		return ordinal_day(d, m, y) + p * 365 + p / 4 - p / 100 + p / 400;
	endfunction

	function automatic calendar_answer_t compute_calendar(logic [IN_TDATA_W-1:0] item);
		calendar_answer_t r;
		int unsigned d, m, y, od, om, oy;
		int unsigned sn_a, sn_b, nd, nm, ny, pd, pm, py;
		logic [31:0] delta;
		d  = 32'(item[4:0]);
		m  = 32'(item[8:5]);
		y  = 32'(item[22:9]);
		od = 32'(item[27:23]);
		om = 32'(item[31:28]);
		oy = 32'(item[45:32]);
		r = '0;
		sn_a = day_count(d, m, y);
		sn_b = day_count(od, om, oy);
		if (real_date(d, m, y)) begin
			nd = d + 1;
			nm = m;
			ny = y;
			if (nd > month_len(m, y)) begin
				nd = 1;
				nm++;
				if (nm > MON_DEC) begin
					nm = 32'(MON_JAN);
					ny++;
				end
			end
			pd = d - 1;
			pm = m;
			py = y;
			if (pd == 0) begin
				if (m == MON_JAN) begin
					pm = 32'(MON_DEC);
					py = y - 1;
				end else begin
					pm = m - 1;
				end
				pd = month_len(pm, py);
			end
			r.valid  = 1'b1;
			r.leap   = is_leap_year(y);
			r.doy    = 9'(ordinal_day(d, m, y));
			r.dn     = 22'(sn_a);
			r.wd     = 3'((sn_a - 1) % 7 + 1);
			r.nday   = 5'(nd);
			r.nmonth = 4'(nm);
			r.nyear  = 14'(ny);
			r.pday   = 5'(pd);
			r.pmonth = 4'(pm);
			r.pyear  = 14'(py);
		end
		delta = sn_a - sn_b;
		r.diff = delta[22:0];
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic logic [IN_TDATA_W-1:0] pack_dates(logic [4:0] d, logic [3:0] m,
			logic [13:0] y, logic [4:0] od, logic [3:0] om, logic [13:0] oy);
		return {{(IN_TDATA_W-46){1'b0}}, oy, om, od, y, m, d};
	endfunction

	task automatic random_date(output logic [4:0] d, output logic [3:0] m,
			output logic [13:0] y);
		y = 14'($urandom_range(1, MAX_YEAR_DEF));
		m = 4'($urandom_range(MON_JAN, MON_DEC));
		d = 5'($urandom_range(1, month_len(m, y)));
	endtask

	// month ends, year ends and century years
	task automatic border_date(output logic [4:0] d, output logic [3:0] m,
			output logic [13:0] y);
		int unsigned len;
		case ($urandom_range(0, 11))
			0: y = 14'd1;
			1: y = 14'd4;
			2: y = 14'd100;
			3: y = 14'd400;
			4: y = 14'd1600;
			5: y = 14'd1700;
			6: y = 14'd1900;
			7: y = 14'd2000;
			8: y = 14'd2100;
			9: y = 14'd9996;
			10: y = 14'(MAX_YEAR_DEF);
			default: y = 14'($urandom_range(1, MAX_YEAR_DEF));
		endcase
		case ($urandom_range(0, 3))
			0: m = MON_JAN;
			1: m = MON_FEB;
			2: m = MON_DEC;
			default: m = 4'($urandom_range(MON_JAN, MON_DEC));
		endcase
		len = month_len(m, y);
		case ($urandom_range(0, 3))
			0: d = 5'd1;
			1: d = 5'd2;
			2: d = 5'(len - 1);
			default: d = 5'(len);
		endcase
	endtask

	// valid date with one field pushed out of range (a zero January day may become 31, valid again)
	task automatic broken_date(output logic [4:0] d, output logic [3:0] m,
			output logic [13:0] y);
		random_date(d, m, y);
		case ($urandom_range(0, 5))
			0: d = '0;
			1: d = 5'($urandom_range(month_len(m, y) + 1, 31));
			2: m = '0;
			3: m = 4'($urandom_range(13, 15));
			4: y = '0;
			default: y = 14'($urandom_range(MAX_YEAR_DEF + 1, 16383));
		endcase
		if (d == 0 && m == MON_JAN && $urandom_range(0, 1)) begin
			d = 5'd31;
		end
	endtask

	function automatic int unsigned tx_idle_len();
		int unsigned r;
		if (hold_left > 0 || sent_cnt % 600 < 150) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned rx_idle_len();
		int unsigned r;
		if (got_cnt % 700 >= 500) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("transaction %0d %s: got %0d, expected %0d",
				got_cnt, name, got, want));
		end
	endtask

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		logic busy;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			tx_gap   <= 0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				expected_answers.push_back(compute_calendar(s_tdata));
				void'(pending_dates.pop_front());
				sent_cnt <= sent_cnt + 1;
				busy = 1'b0;
			end
			if (!busy) begin
				if (tx_gap > 0) begin
					tx_gap   <= tx_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_dates.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_dates[0];
					tx_gap   <= tx_idle_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------- receiver ready ----------------
	always @(posedge clk or negedge arst_n) begin
		int unsigned gap;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			rx_wait   <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (!hold_done && sent_cnt >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait  <= rx_wait - 1;
			m_tready <= 1'b0;
		end else begin
			gap = rx_idle_len();
			if (gap == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				rx_wait  <= gap - 1;
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		calendar_answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_answers.size() == 0) begin
				report_mismatch($sformatf("transaction %0d arrived with nothing pending",
					got_cnt));
			end else begin
				want = expected_answers.pop_front();
				check_field("is_valid", m_tuser, want.valid);
				check_field("is_leap", m_tdata[0], want.leap);
				check_field("day_of_year", m_tdata[9:1], want.doy);
				check_field("day_number", m_tdata[31:10], want.dn);
				check_field("weekday", m_tdata[34:32], want.wd);
				check_field("next_day", m_tdata[39:35], want.nday);
				check_field("next_month", m_tdata[43:40], want.nmonth);
				check_field("next_year", m_tdata[57:44], want.nyear);
				check_field("prev_day", m_tdata[62:58], want.pday);
				check_field("prev_month", m_tdata[66:63], want.pmonth);
				check_field("prev_year", m_tdata[80:67], want.pyear);
				check_field("day_difference", m_tdata[103:81], want.diff);
			end
			got_cnt <= got_cnt + 1;
		end
	end

	// ---------------- sequence ----------------
	initial begin
		logic [4:0]  d, od;
		logic [3:0]  m, om;
		logic [13:0] y, oy;
		int unsigned sel;

		// first day ever, last day, leap rules, month and year rollovers, bad fields
		pending_dates.push_back(pack_dates(1, MON_JAN, 1, 1, MON_JAN, 1));
		pending_dates.push_back(pack_dates(31, MON_DEC, 9999, 1, MON_JAN, 1));
		pending_dates.push_back(pack_dates(1, MON_JAN, 1, 31, MON_DEC, 9999));
		pending_dates.push_back(pack_dates(29, MON_FEB, 2000, 28, MON_FEB, 1900));
		pending_dates.push_back(pack_dates(29, MON_FEB, 1900, 1, MON_MAR, 1900));
		pending_dates.push_back(pack_dates(29, MON_FEB, 2024, 29, MON_FEB, 2023));
		pending_dates.push_back(pack_dates(28, MON_FEB, 2023, 1, MON_JAN, 2023));
		pending_dates.push_back(pack_dates(1, MON_MAR, 2024, 1, MON_MAR, 2023));
		pending_dates.push_back(pack_dates(1, MON_MAR, 2023, 31, MON_JAN, 2024));
		pending_dates.push_back(pack_dates(31, MON_JAN, 2024, 30, MON_APR, 2021));
		pending_dates.push_back(pack_dates(30, MON_APR, 2021, 31, MON_APR, 2021));
		pending_dates.push_back(pack_dates(1, MON_JAN, 2000, 31, MON_DEC, 1999));
		pending_dates.push_back(pack_dates(31, MON_DEC, 1999, 1, MON_JAN, 2000));
		pending_dates.push_back(pack_dates(0, MON_MAY, 2020, 10, MON_MAY, 2020));
		pending_dates.push_back(pack_dates(10, 0, 2020, 10, 0, 2020));
		pending_dates.push_back(pack_dates(31, 13, 2020, 1, 15, 2020));
		pending_dates.push_back(pack_dates(1, MON_JAN, 0, 1, MON_JAN, 0));
		pending_dates.push_back(pack_dates(1, MON_JAN, 10000, 31, MON_DEC, 9999));
		pending_dates.push_back(pack_dates(5'h1f, 4'hf, 14'h3fff, 5'h1f, 4'hf, 14'h3fff));
		pending_dates.push_back(pack_dates(0, 0, 0, 0, 0, 0));
		pending_dates.push_back(pack_dates(31, MON_DEC, 2023, 31, MON_DEC, 2023));
		pending_dates.push_back(pack_dates(15, MON_JUN, 1582, 15, MON_OCT, 1582));
		pending_dates.push_back(pack_dates(31, MON_JUN, 2022, 29, MON_FEB, 9996));
		pending_dates.push_back(pack_dates(29, MON_FEB, 9996, 7, MON_JUL, 4321));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				random_date(d, m, y);
			end else if (sel < 75) begin
				border_date(d, m, y);
			end else if (sel < 90) begin
				broken_date(d, m, y);
			end else begin
				d = 5'($urandom);
				m = 4'($urandom);
				y = 14'($urandom);
			end
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				random_date(od, om, oy);
			end else if (sel < 80) begin
				border_date(od, om, oy);
			end else if (sel < 88) begin
				od = d;
				om = m;
				oy = y;
			end else if (sel < 94) begin
				broken_date(od, om, oy);
			end else begin
				od = 5'($urandom);
				om = 4'($urandom);
				oy = 14'($urandom);
			end
			pending_dates.push_back(pack_dates(d, m, y, od, om, oy));
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_dates.size() > 0 || s_tvalid) begin
			@(posedge clk);
		end
		while (expected_answers.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("gregorian_date_arithmetic_unit regression: pass");
		end else begin
			$display("gregorian_date_arithmetic_unit regression: fail");
		end
		$finish;
	end

	initial begin
		#6_000_000;
		$display("timeout waiting for transactions");
		$display("gregorian_date_arithmetic_unit regression: fail");
		$finish;
	end

endmodule

[gregorian_date_arithmetic_unit.f]
sv/gda_pkg.sv
sv/gregorian_date_arithmetic_unit.sv
dv/tb_gregorian_date_arithmetic_unit.sv
